/* hdl/trb_pkg.sv */
`timescale 1ns / 1ps

package trb_pkg;

  // item selector codes
  localparam logic [1:0] FUNC_DRAW2 = 2'd0;
  localparam logic [1:0] FUNC_DRAW1 = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // per-pixel draw codes
  localparam logic [1:0] PIX_CLR  = 2'd0;
  localparam logic [1:0] PIX_XOR  = 2'd1;
  localparam logic [1:0] PIX_SKIP = 2'd2;
  localparam logic [1:0] PIX_SET  = 2'd3;

  // frame store split into an even-column bank and an odd-column bank
  localparam int BANK_AW    = 9;
  localparam int BANK_DEPTH = 512;

  // one read-modify-write on one bank byte
  typedef struct packed {
    logic               wr;
    logic [BANK_AW-1:0] ent;
    logic [7:0]         clr;
    logic [7:0]         xr;
    logic [7:0]         st;
  } byte_op_t;

  typedef struct packed {
    byte_op_t even;
    byte_op_t odd;
  } plan_t;

endpackage

/* hdl/trb_plan.sv */
`timescale 1ns / 1ps

module trb_plan #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic [1:0]        func,
  input  logic [15:0]       row_bits,
  input  logic signed [7:0] tile_x,
  input  logic signed [7:0] tile_y,
  input  logic [2:0]        tile_row,
  input  logic              flip_h,
  input  logic              flip_v,
  input  logic [9:0]        read_addr,
  output trb_pkg::plan_t    plan
);

  localparam logic signed [9:0] WIDTH_S  = 10'(SCREEN_WIDTH);
  localparam logic signed [8:0] HEIGHT_S = 9'(SCREEN_HEIGHT);

  logic [1:0]        tcode [8];
  logic [1:0]        scode [8];
  logic [1:0]        wcode [16];
  logic [15:0]       wuse;
  logic [3:0]        dj;
  logic [2:0]        yrow;
  logic signed [8:0] ypos;
  logic              y_ok;
  logic              drawing;
  logic signed [9:0] xbase;
  logic signed [9:0] xj;
  logic              pix_ok;
  logic [7:0]        clr_a, xr_a, st_a, clr_b, xr_b, st_b;
  logic [3:0]        col_a, col_b;
  trb_pkg::byte_op_t op_a, op_b;

  always_comb begin
    drawing = (func == trb_pkg::FUNC_DRAW2) || (func == trb_pkg::FUNC_DRAW1);
    yrow    = flip_v ? (3'd7 - tile_row) : tile_row;
    ypos    = {tile_y[7], tile_y} + $signed({6'd0, yrow});
    y_ok    = (ypos >= 9'sd0) && (ypos < HEIGHT_S);
    xbase   = {{2{tile_x[7]}}, tile_x[7:3], 3'b000};

    // tile pixel codes, 1bpp maps to set or clear
    for (int k = 0; k < 8; k++) begin
      if (func == trb_pkg::FUNC_DRAW2) begin
        tcode[k] = row_bits[15-2*k -: 2];
      end else begin
        tcode[k] = row_bits[7-k] ? trb_pkg::PIX_SET : trb_pkg::PIX_CLR;
      end
    end
    for (int i = 0; i < 8; i++) begin
      scode[i] = flip_h ? tcode[7-i] : tcode[i];
    end

    // place the eight screen pixels into a 16-pixel window at the byte offset
    wuse = '0;
    for (int j = 0; j < 16; j++) begin
      dj       = 4'(j) - {1'b0, tile_x[2:0]};
      wcode[j] = scode[dj[2:0]];
      wuse[j]  = (4'(j) >= {1'b0, tile_x[2:0]}) && (dj < 4'd8);
    end

    clr_a = '0; xr_a = '0; st_a = '0;
    clr_b = '0; xr_b = '0; st_b = '0;
    for (int j = 0; j < 16; j++) begin
      xj     = xbase + $signed(10'(j));
      pix_ok = drawing && y_ok && wuse[j] && (xj >= 10'sd0) && (xj < WIDTH_S);
      if (j < 8) begin
        clr_a[7-j] = pix_ok && (wcode[j] == trb_pkg::PIX_CLR);
        xr_a[7-j]  = pix_ok && (wcode[j] == trb_pkg::PIX_XOR);
        st_a[7-j]  = pix_ok && (wcode[j] == trb_pkg::PIX_SET);
      end else begin
        clr_b[15-j] = pix_ok && (wcode[j] == trb_pkg::PIX_CLR);
        xr_b[15-j]  = pix_ok && (wcode[j] == trb_pkg::PIX_XOR);
        st_b[15-j]  = pix_ok && (wcode[j] == trb_pkg::PIX_SET);
      end
    end

    col_a = tile_x[6:3];
    col_b = col_a + 4'd1;

    op_a.wr  = drawing;
    op_a.ent = drawing ? {ypos[5:0], col_a[3:1]} : read_addr[9:1];
    op_a.clr = clr_a;
    op_a.xr  = xr_a;
    op_a.st  = st_a;

    op_b.wr  = drawing;
    op_b.ent = drawing ? {ypos[5:0], col_b[3:1]} : read_addr[9:1];
    op_b.clr = clr_b;
    op_b.xr  = xr_b;
    op_b.st  = st_b;

    // left byte sits in the odd bank when its column is odd
    if (tile_x[3]) begin
      plan.even = op_b;
      plan.odd  = op_a;
    end else begin
      plan.even = op_a;
      plan.odd  = op_b;
    end
  end

endmodule

/* hdl/trb_bank.sv */
`timescale 1ns / 1ps

module trb_bank (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  trb_pkg::byte_op_t           op,
  input  logic                        clear_en,
  input  logic [trb_pkg::BANK_AW-1:0] clear_ent,
  output logic [7:0]                  rd_data
);

  logic [7:0]        mem [trb_pkg::BANK_DEPTH];
  trb_pkg::byte_op_t op_q;
  logic              pend;
  logic [7:0]        new_byte;

  always_comb begin
    new_byte = ((rd_data & ~op_q.clr) ^ op_q.xr) | op_q.st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start;
    end
  end

  // read the old byte at start, write the merged byte in the cycle after, when pend is set
  always_ff @(posedge clk) begin
    if (start) begin
      rd_data <= mem[op.ent];
      op_q    <= op;
    end
    if (clear_en) begin
      mem[clear_ent] <= 8'd0;
    end else if (pend && op_q.wr) begin
      mem[op_q.ent] <= new_byte;
    end
  end

endmodule

/* hdl/tile_row_blitter_with_flip.sv */
`timescale 1ns / 1ps

// Tile-row blitter into a 128x64 one-bit framebuffer, 16 bytes per row,
// pixels MSB-first.
// Input channel (in_valid/in_ready): one beat per item. func selects a 2bpp
// draw (clear, xor, skip, set per pixel), a 1bpp draw (overwrite) or a read
// of one framebuffer byte at read_addr. Draws honor flip_h and flip_v and
// drop every pixel that falls off the visible screen.
// Output channel (out_valid/out_ready): exactly one beat per input beat,
// read_data holding the byte for reads and zero for everything else.
// Result path: the accepted beat sets busy for its merge cycle, and while busy
// is set the result is loaded into read_data and out_valid is raised.
// A new item is not taken while busy is set, because of the read-modify-write
// on the single port of each frame store bank (even and odd byte columns,
// so the two bytes a row touches are handled in the same pass).
// Reset: rst clears control at once, then a clearing pass zeroes all 512
// entries of both banks, during which in_ready stays low.
// Stall: a result waits in the output register while out_ready is low; a new
// beat is taken only when that register is empty or drains in the same cycle.
module tile_row_blitter_with_flip #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [15:0]       row_bits,
  input  logic signed [7:0] tile_x,
  input  logic signed [7:0] tile_y,
  input  logic [2:0]        tile_row,
  input  logic              flip_h,
  input  logic              flip_v,
  input  logic [9:0]        read_addr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        read_data
);

  trb_pkg::plan_t plan;
  logic           accept;
  logic [9:0]     clr_cnt;   // bit 9 set once the clearing pass is over
  logic           clearing;
  logic           busy;      // merge cycle of the accepted item
  logic           is_read;
  logic           rd_bank;
  logic [7:0]     even_rd;
  logic [7:0]     odd_rd;

  assign clearing = !clr_cnt[9];
  assign in_ready = !clearing && !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // build byte ops for both banks from the beat
  trb_plan #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_plan (
    .func     (func),
    .row_bits (row_bits),
    .tile_x   (tile_x),
    .tile_y   (tile_y),
    .tile_row (tile_row),
    .flip_h   (flip_h),
    .flip_v   (flip_v),
    .read_addr(read_addr),
    .plan     (plan)
  );

  trb_bank u_even (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .op       (plan.even),
    .clear_en (clearing),
    .clear_ent(clr_cnt[trb_pkg::BANK_AW-1:0]),
    .rd_data  (even_rd)
  );

  trb_bank u_odd (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .op       (plan.odd),
    .clear_en (clearing),
    .clear_ent(clr_cnt[trb_pkg::BANK_AW-1:0]),
    .rd_data  (odd_rd)
  );

  // advance the clearing pass, one entry of each bank per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 10'd1;
    end
  end

  // hold what the merge cycle needs to pick the result
  always_ff @(posedge clk) begin
    if (accept) begin
      is_read <= (func == trb_pkg::FUNC_READ);
      rd_bank <= read_addr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= accept;
      if (busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // load the result beat; draws and unused codes return zero
  always_ff @(posedge clk) begin
    if (busy) begin
      if (is_read) begin
        read_data <= rd_bank ? odd_rd : even_rd;
      end else begin
        read_data <= 8'd0;
      end
    end
  end

endmodule
